// File: src/row_sort_by_column_core_defines.svh
// Assertion macros for the row sort core.
// Used by row_sort_by_column_core.sv; expects i_clk and i_rst_n in scope.
`ifndef ROW_SORT_BY_COLUMN_CORE_DEFINES_SVH
`define ROW_SORT_BY_COLUMN_CORE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define RSBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RSBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rsbc_pkg.sv
// Package for the row sort core: sizes, row and range types, FSM states.
// No dependencies; used by row_sort_by_column_core.sv.
`timescale 1ns / 1ps

package rsbc_pkg;

    localparam int ROWS = 32;                 // batch capacity
    localparam int AW   = $clog2(ROWS);       // row address width
    localparam int CW   = $clog2(ROWS + 1);   // row count / scan index width
    localparam int SD   = ROWS + 2;           // range stack depth
    localparam int SAW  = $clog2(SD);         // stack address width
    localparam int SPW  = $clog2(SD + 1);     // stack pointer width
    localparam int IDXW = 5;                  // source_index width
    localparam int SW   = 32;                 // score width

    typedef struct packed {
        logic [3:0][SW-1:0] score;            // score[0] in the low bits
        logic [IDXW-1:0]    idx;
    } t_row;

    typedef struct packed {
        logic [AW-1:0] lo;
        logic [AW-1:0] hi;
    } t_range;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PIVOT,
        ST_PIVOT_WAIT,
        ST_SCAN_I,
        ST_SCAN_I_CHK,
        ST_SCAN_J,
        ST_SCAN_J_CHK,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_PUSH_HI,
        ST_PUSH_LO,
        ST_POP,
        ST_POP_WAIT,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    function automatic logic signed [SW-1:0] row_key(t_row row, logic [1:0] col);
        return $signed(row.score[col]);
    endfunction

endpackage

// File: src/row_sort_by_column_core.sv
// Row sort core: loads a batch of score rows, quicksorts them on one column,
// streams them out with their load index. Depends on rsbc_pkg and the defines header.
`timescale 1ns / 1ps
`include "row_sort_by_column_core_defines.svh"

// Channel   | Dir | Signals                      | Contents
// ----------+-----+------------------------------+-------------------------------------
// s_axis    | in  | tvalid tready tdata tlast    | one row of four Q16.16 scores
// m_axis    | out | tvalid tready tdata tlast    | sorted row, index, final and drop
//           |     | tuser                        | flags
// cfg       | in  | i_cfg_we i_cfg_wdata         | sort column
//
// Loading accepts one row per cycle. After the last row the rows are sorted in place,
// one compare at a time: pivot fetch is a read then a key capture, a scan step a read
// then a check, a swap two write halves, a partition end a high then a low range push,
// a pop a read then a bound check (quadratic worst case). Each output row is a read
// then a load held by any m_axis stall. No request is taken during sort or output.
// Reset is synchronous, active low, clears control only; RAMs hold no reset state.

module row_sort_by_column_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_wdata,      // sort_column
    // row input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,     // score_first, score_second, score_third, score_fourth
    input  logic         s_axis_tlast,     // last_row
    // sorted output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,     // source_index, out_first..out_fourth, 3 zero bits
    output logic         m_axis_tlast,     // final_out
    output logic         m_axis_tuser      // dropped_rows
);

    // ---------------------------------------------------------------
    // state and datapath registers
    // ---------------------------------------------------------------
    rsbc_pkg::t_state r_state, n_state;

    logic [1:0]                    r_sort_col;
    logic [rsbc_pkg::CW-1:0]       r_count;     // rows held in this batch
    logic                          r_overflow;  // set if rows were dropped this batch
    logic [rsbc_pkg::AW-1:0]       r_l, r_r;    // current partition bounds
    logic [rsbc_pkg::CW-1:0]       r_i, r_j;    // Hoare scan indices (i wraps at l-1)
    logic signed [rsbc_pkg::SW-1:0] r_x;        // pivot key
    logic [rsbc_pkg::SPW-1:0]      r_sp;        // range stack pointer
    logic [rsbc_pkg::CW-1:0]       r_k;         // output row counter

    // row RAM: one write port, two registered read ports
    rsbc_pkg::t_row r_mem [rsbc_pkg::ROWS];
    rsbc_pkg::t_row r_rd_a, r_rd_b;
    // range stack RAM
    rsbc_pkg::t_range r_stk [rsbc_pkg::SD];
    rsbc_pkg::t_range r_stk_rd;

    // output register
    logic           r_out_valid;
    rsbc_pkg::t_row r_out_row;
    logic           r_out_last;
    logic           r_out_drop;

    // ---------------------------------------------------------------
    // combinational helpers
    // ---------------------------------------------------------------
    logic                     in_accept;
    logic                     full;
    logic [rsbc_pkg::CW-1:0]  cnt_after;
    logic [rsbc_pkg::AW:0]    mid_sum;
    logic [rsbc_pkg::AW-1:0]  mid;
    logic signed [rsbc_pkg::SW-1:0] key_a, key_b;
    logic [rsbc_pkg::CW-1:0]  j_plus;
    logic                     push_hi_ok, push_lo_ok;
    logic                     out_free;
    logic                     emit_last;

    assign full      = (r_count == rsbc_pkg::CW'(rsbc_pkg::ROWS));
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign cnt_after = full ? r_count : r_count + rsbc_pkg::CW'(1);
    assign mid_sum   = {1'b0, r_l} + {1'b0, r_r};
    assign mid       = mid_sum[rsbc_pkg::AW:1];
    assign key_a     = rsbc_pkg::row_key(r_rd_a, r_sort_col);
    assign key_b     = rsbc_pkg::row_key(r_rd_b, r_sort_col);
    assign j_plus    = r_j + rsbc_pkg::CW'(1);
    assign push_hi_ok = (j_plus < rsbc_pkg::CW'(r_r))
                        && (r_sp < rsbc_pkg::SPW'(rsbc_pkg::SD));
    assign push_lo_ok = (rsbc_pkg::CW'(r_l) < r_j)
                        && (r_sp < rsbc_pkg::SPW'(rsbc_pkg::SD));
    assign out_free  = !r_out_valid || m_axis_tready;
    assign emit_last = (r_k == r_count - rsbc_pkg::CW'(1));

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsbc_pkg::ST_LOAD: begin
                if (in_accept && s_axis_tlast) begin
                    n_state = (cnt_after >= rsbc_pkg::CW'(2)) ? rsbc_pkg::ST_PIVOT
                                                              : rsbc_pkg::ST_EMIT_RD;
                end
            end
            rsbc_pkg::ST_PIVOT:      n_state = rsbc_pkg::ST_PIVOT_WAIT;
            rsbc_pkg::ST_PIVOT_WAIT: n_state = rsbc_pkg::ST_SCAN_I;
            rsbc_pkg::ST_SCAN_I:     n_state = rsbc_pkg::ST_SCAN_I_CHK;
            rsbc_pkg::ST_SCAN_I_CHK: begin
                if ((r_i < rsbc_pkg::CW'(r_r)) && (key_a < r_x)) begin
                    n_state = rsbc_pkg::ST_SCAN_I;
                end else begin
                    n_state = rsbc_pkg::ST_SCAN_J;
                end
            end
            rsbc_pkg::ST_SCAN_J:     n_state = rsbc_pkg::ST_SCAN_J_CHK;
            rsbc_pkg::ST_SCAN_J_CHK: begin
                if ((r_j > rsbc_pkg::CW'(r_l)) && (key_b > r_x)) begin
                    n_state = rsbc_pkg::ST_SCAN_J;
                end else if (r_i < r_j) begin
                    n_state = rsbc_pkg::ST_SWAP_A;
                end else begin
                    n_state = rsbc_pkg::ST_PUSH_HI;
                end
            end
            rsbc_pkg::ST_SWAP_A:     n_state = rsbc_pkg::ST_SWAP_B;
            rsbc_pkg::ST_SWAP_B:     n_state = rsbc_pkg::ST_SCAN_I;
            rsbc_pkg::ST_PUSH_HI:    n_state = rsbc_pkg::ST_PUSH_LO;
            rsbc_pkg::ST_PUSH_LO:    n_state = rsbc_pkg::ST_POP;
            rsbc_pkg::ST_POP: begin
                n_state = (r_sp == '0) ? rsbc_pkg::ST_EMIT_RD : rsbc_pkg::ST_POP_WAIT;
            end
            rsbc_pkg::ST_POP_WAIT: begin
                n_state = (r_stk_rd.lo < r_stk_rd.hi) ? rsbc_pkg::ST_PIVOT
                                                      : rsbc_pkg::ST_POP;
            end
            rsbc_pkg::ST_EMIT_RD:    n_state = rsbc_pkg::ST_EMIT_LD;
            rsbc_pkg::ST_EMIT_LD: begin
                if (out_free) begin
                    n_state = emit_last ? rsbc_pkg::ST_LOAD : rsbc_pkg::ST_EMIT_RD;
                end
            end
            default:                 n_state = rsbc_pkg::ST_LOAD;
        endcase
    end

    // ---------------------------------------------------------------
    // control outputs: RAM strobes, input ready, output load
    // ---------------------------------------------------------------
    logic                    mem_we;
    logic [rsbc_pkg::AW-1:0] mem_waddr;
    rsbc_pkg::t_row          mem_wdata;
    logic                    rd_en_a, rd_en_b;
    logic [rsbc_pkg::AW-1:0] rd_addr_a, rd_addr_b;
    logic                    stk_we;
    logic [rsbc_pkg::SAW-1:0] stk_waddr;
    rsbc_pkg::t_range        stk_wdata;
    logic                    stk_re;
    logic [rsbc_pkg::SAW-1:0] stk_raddr;
    logic                    out_load;
    logic [rsbc_pkg::CW-1:0] i_next, j_next;

    assign i_next = r_i + rsbc_pkg::CW'(1);
    assign j_next = r_j - rsbc_pkg::CW'(1);

    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_i[rsbc_pkg::AW-1:0];
        mem_wdata     = r_rd_b;
        rd_en_a       = 1'b0;
        rd_en_b       = 1'b0;
        rd_addr_a     = i_next[rsbc_pkg::AW-1:0];
        rd_addr_b     = j_next[rsbc_pkg::AW-1:0];
        stk_we        = 1'b0;
        stk_waddr     = r_sp[rsbc_pkg::SAW-1:0];
        stk_wdata     = '{lo: j_plus[rsbc_pkg::AW-1:0], hi: r_r};
        stk_re        = 1'b0;
        stk_raddr     = rsbc_pkg::SAW'(r_sp - rsbc_pkg::SPW'(1));
        out_load      = 1'b0;
        case (r_state)
            rsbc_pkg::ST_LOAD: begin
                s_axis_tready = 1'b1;
                mem_we        = s_axis_tvalid && !full;
                mem_waddr     = r_count[rsbc_pkg::AW-1:0];
                mem_wdata     = '{score: s_axis_tdata, idx: rsbc_pkg::IDXW'(r_count)};
            end
            rsbc_pkg::ST_PIVOT: begin
                rd_en_a   = 1'b1;
                rd_addr_a = mid;
            end
            rsbc_pkg::ST_SCAN_I:  rd_en_a = 1'b1;
            rsbc_pkg::ST_SCAN_J:  rd_en_b = 1'b1;
            rsbc_pkg::ST_SWAP_A: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[rsbc_pkg::AW-1:0];
                mem_wdata = r_rd_b;
            end
            rsbc_pkg::ST_SWAP_B: begin
                mem_we    = 1'b1;
                mem_waddr = r_j[rsbc_pkg::AW-1:0];
                mem_wdata = r_rd_a;
            end
            rsbc_pkg::ST_PUSH_HI: stk_we = push_hi_ok;
            rsbc_pkg::ST_PUSH_LO: begin
                stk_we    = push_lo_ok;
                stk_wdata = '{lo: r_l, hi: r_j[rsbc_pkg::AW-1:0]};
            end
            rsbc_pkg::ST_POP:     stk_re = (r_sp != '0);
            rsbc_pkg::ST_EMIT_RD: begin
                rd_en_a   = 1'b1;
                rd_addr_a = r_k[rsbc_pkg::AW-1:0];
            end
            rsbc_pkg::ST_EMIT_LD: out_load = out_free;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // memories
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en_a) begin
            r_rd_a <= r_mem[rd_addr_a];
        end
        if (rd_en_b) begin
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_rd <= r_stk[stk_raddr];
        end
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsbc_pkg::ST_LOAD;
            r_sort_col  <= 2'd0;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_sp        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_sort_col <= i_cfg_wdata;
            end
            case (r_state)
                rsbc_pkg::ST_LOAD: begin
                    if (in_accept) begin
                        r_count <= cnt_after;
                        if (full) begin
                            r_overflow <= 1'b1;
                        end
                        r_sp <= '0;
                        r_k  <= '0;
                    end
                end
                rsbc_pkg::ST_PUSH_HI: if (push_hi_ok) r_sp <= r_sp + rsbc_pkg::SPW'(1);
                rsbc_pkg::ST_PUSH_LO: if (push_lo_ok) r_sp <= r_sp + rsbc_pkg::SPW'(1);
                rsbc_pkg::ST_POP:     if (r_sp != '0) r_sp <= r_sp - rsbc_pkg::SPW'(1);
                rsbc_pkg::ST_EMIT_LD: begin
                    if (out_free) begin
                        r_k <= r_k + rsbc_pkg::CW'(1);
                        if (emit_last) begin
                            // batch done, start a fresh one
                            r_count    <= '0;
                            r_overflow <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_sp <= r_sp;
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // partition datapath (no reset needed)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            rsbc_pkg::ST_LOAD: begin
                // whole batch is the first range
                r_l <= '0;
                r_r <= rsbc_pkg::AW'(cnt_after - rsbc_pkg::CW'(1));
            end
            rsbc_pkg::ST_PIVOT: begin
                r_i <= rsbc_pkg::CW'(r_l) - rsbc_pkg::CW'(1);
                r_j <= rsbc_pkg::CW'(r_r) + rsbc_pkg::CW'(1);
            end
            rsbc_pkg::ST_PIVOT_WAIT: r_x <= key_a;
            rsbc_pkg::ST_SCAN_I:     r_i <= i_next;
            rsbc_pkg::ST_SCAN_J:     r_j <= j_next;
            rsbc_pkg::ST_POP_WAIT: begin
                r_l <= r_stk_rd.lo;
                r_r <= r_stk_rd.hi;
            end
            default: begin
                r_x <= r_x;
            end
        endcase
        if (out_load) begin
            r_out_row  <= r_rd_a;
            r_out_last <= emit_last;
            r_out_drop <= r_overflow;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_row};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_drop;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `RSBC_ASSERT(a_count_cap, r_count <= rsbc_pkg::ROWS, "row count beyond capacity")
    `RSBC_ASSERT(a_stack_cap, r_sp <= rsbc_pkg::SD, "range stack pointer beyond depth")
    `RSBC_ASSERT(a_scan_i_bound, (r_state != rsbc_pkg::ST_SCAN_I_CHK) || (r_i <= r_r),
                 "i scan ran past right bound")
    `RSBC_ASSERT(a_swap_order, (r_state != rsbc_pkg::ST_SWAP_A) || (r_i < r_j),
                 "swap with i not below j")
    `RSBC_ASSERT(a_emit_range, (r_state != rsbc_pkg::ST_EMIT_LD) || (r_k < r_count),
                 "output index beyond batch")
    `RSBC_ASSERT_NEXT(a_batch_clear, out_load && emit_last, (r_count == '0) && !r_overflow,
                      "batch not cleared after final row")

endmodule
